// File: hdl/rectangle_support_point_unit_defines.svh
// Assertion macros shared by the rectangle support point unit.
`ifndef RECTANGLE_SUPPORT_POINT_UNIT_DEFINES_SVH
`define RECTANGLE_SUPPORT_POINT_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define RSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsp: same-cycle check failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define RSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsp: next-cycle check failed");

`endif

// File: hdl/rsp_pkg.sv
// Types and constants of the rectangle support point unit.
package rsp_pkg;

  localparam int unsigned DirW   = 16;
  localparam int unsigned ExtW   = 16;
  localparam int unsigned RowW   = 48;
  localparam int unsigned CompW  = 16;
  localparam int unsigned PointW = 20;
  localparam int unsigned ProdW  = 32;
  localparam int unsigned SumW   = 34;
  localparam int unsigned AxisW  = 33;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RECT_WIDTH      = 3'd0,
    REG_RECT_DEPTH      = 3'd1,
    REG_AXIS_X_ROW      = 3'd2,
    REG_AXIS_Z_ROW      = 3'd3,
    REG_TRANSLATION_ROW = 3'd4
  } cfg_reg_t;

  localparam logic [ExtW-1:0] RECT_WIDTH_RST      = 16'd256;
  localparam logic [ExtW-1:0] RECT_DEPTH_RST      = 16'd256;
  localparam logic [RowW-1:0] AXIS_X_ROW_RST      = 48'h0000_0000_4000;
  localparam logic [RowW-1:0] AXIS_Z_ROW_RST      = 48'h4000_0000_0000;
  localparam logic [RowW-1:0] TRANSLATION_ROW_RST = 48'h0000_0000_0000;

  typedef enum logic [1:0] {
    CORNER_NEG_NEG = 2'd0,
    CORNER_POS_NEG = 2'd1,
    CORNER_POS_POS = 2'd2,
    CORNER_NEG_POS = 2'd3
  } corner_t;

  typedef struct packed {
    logic signed [DirW-1:0] dir_x;
    logic signed [DirW-1:0] dir_y;
    logic signed [DirW-1:0] dir_z;
  } in_item_t;

  typedef struct packed {
    logic signed [PointW-1:0] point_x;
    logic signed [PointW-1:0] point_y;
    logic signed [PointW-1:0] point_z;
    logic [1:0]               corner_index;
  } out_item_t;

  // Stage enables and the chosen corner signs, shared by all lanes.
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic sx_pos;
    logic sz_pos;
  } lane_ctrl_t;

endpackage

// File: hdl/rsp_lane.sv
// One world axis lane: direction products, corner offset terms and rounded coordinate.
module rsp_lane (
  input  logic                                   clk,
  input  rsp_pkg::lane_ctrl_t                    ctrl,
  input  logic signed [rsp_pkg::DirW-1:0]        dir,
  input  logic signed [rsp_pkg::CompW-1:0]       ax,
  input  logic signed [rsp_pkg::CompW-1:0]       az,
  input  logic        [rsp_pkg::ExtW-1:0]        w,
  input  logic        [rsp_pkg::ExtW-1:0]        d,
  input  logic signed [rsp_pkg::CompW-1:0]       t,
  output logic signed [rsp_pkg::ProdW-1:0]       prod_x_r,
  output logic signed [rsp_pkg::ProdW-1:0]       prod_z_r,
  output logic signed [rsp_pkg::PointW-1:0]      coord_r
);

  localparam int unsigned VW = 36;
  localparam int unsigned RW = VW - 15;

  logic signed [rsp_pkg::ExtW:0]          w_s;
  logic signed [rsp_pkg::ExtW:0]          d_s;
  logic signed [rsp_pkg::ProdW-1:0]       prod_x_nxt;
  logic signed [rsp_pkg::ProdW-1:0]       prod_z_nxt;
  logic signed [rsp_pkg::AxisW-1:0]       wax_nxt;
  logic signed [rsp_pkg::AxisW-1:0]       daz_nxt;
  logic signed [rsp_pkg::AxisW-1:0]       wax1_r;
  logic signed [rsp_pkg::AxisW-1:0]       daz1_r;
  logic signed [rsp_pkg::CompW-1:0]       t1_r;
  logic signed [rsp_pkg::AxisW-1:0]       wax2_r;
  logic signed [rsp_pkg::AxisW-1:0]       daz2_r;
  logic signed [rsp_pkg::CompW-1:0]       t2_r;
  logic signed [VW-1:0]                   t_term;
  logic signed [VW-1:0]                   x_term;
  logic signed [VW-1:0]                   z_term;
  logic signed [VW-1:0]                   v_sum;
  logic signed [RW-1:0]                   v_round;
  logic signed [rsp_pkg::PointW-1:0]      coord_nxt;

  assign w_s        = {1'b0, w};
  assign d_s        = {1'b0, d};
  assign prod_x_nxt = dir * ax;
  assign prod_z_nxt = dir * az;
  assign wax_nxt    = w_s * ax;
  assign daz_nxt    = d_s * az;

  // Corner coordinate in Q.23, then round half up to Q.8.
  assign t_term  = VW'(t2_r) <<< 15;
  assign x_term  = ctrl.sx_pos ? VW'(wax2_r) : -VW'(wax2_r);
  assign z_term  = ctrl.sz_pos ? VW'(daz2_r) : -VW'(daz2_r);
  assign v_sum   = t_term + x_term + z_term + (VW'(1) <<< 14);
  assign v_round = v_sum[VW-1:15];

  always_comb begin
    if (v_round > RW'(signed'({1'b0, {(rsp_pkg::PointW-1){1'b1}}}))) begin
      coord_nxt = {1'b0, {(rsp_pkg::PointW-1){1'b1}}};
    end else if (v_round < -RW'(signed'({1'b0, 1'b1, {(rsp_pkg::PointW-1){1'b0}}}))) begin
      coord_nxt = {1'b1, {(rsp_pkg::PointW-1){1'b0}}};
    end else begin
      coord_nxt = v_round[rsp_pkg::PointW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en1) begin
      prod_x_r <= prod_x_nxt;
      prod_z_r <= prod_z_nxt;
      wax1_r   <= wax_nxt;
      daz1_r   <= daz_nxt;
      t1_r     <= t;
    end
    if (ctrl.en2) begin
      wax2_r <= wax1_r;
      daz2_r <= daz1_r;
      t2_r   <= t1_r;
    end
    if (ctrl.en3) begin
      coord_r <= coord_nxt;
    end
  end

endmodule

// File: hdl/rectangle_support_point_unit.sv
// One item per cycle sustained while out_stall is low; a full pipeline with a stalled output raises in_stall.
// Stage 1 multiplies direction and corner terms, stage 2 sums projections,
// stage 3 picks the corner by projection sign and rounds the coordinates.
// Each stage advances when the next one is empty or advancing, so bubbles collapse.
// Synchronous active-low reset empties the pipeline and restores the register defaults.
`include "rectangle_support_point_unit_defines.svh"

module rectangle_support_point_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rsp_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rsp_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [rsp_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [rsp_pkg::RowW-1:0]            cfg_wdata
);

  logic [rsp_pkg::ExtW-1:0] rect_width_r;
  logic [rsp_pkg::ExtW-1:0] rect_depth_r;
  logic [rsp_pkg::RowW-1:0] axis_x_r;
  logic [rsp_pkg::RowW-1:0] axis_z_r;
  logic [rsp_pkg::RowW-1:0] trans_r;

  logic v1_r;
  logic v2_r;
  logic v3_r;
  logic en1;
  logic en2;
  logic en3;

  logic signed [rsp_pkg::ProdW-1:0]  prod_x [3];
  logic signed [rsp_pkg::ProdW-1:0]  prod_z [3];
  logic signed [rsp_pkg::PointW-1:0] coord  [3];
  logic signed [rsp_pkg::DirW-1:0]   dir    [3];

  logic signed [rsp_pkg::SumW-1:0] sa_nxt;
  logic signed [rsp_pkg::SumW-1:0] sb_nxt;
  logic signed [rsp_pkg::SumW-1:0] sa_r;
  logic signed [rsp_pkg::SumW-1:0] sb_r;

  logic px_pos;
  logic px_zero;
  logic pz_pos;
  logic sx_pos;
  logic sz_pos;
  rsp_pkg::corner_t     corner_nxt;
  rsp_pkg::corner_t     corner_r;
  rsp_pkg::lane_ctrl_t  ctrl;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_width_r <= rsp_pkg::RECT_WIDTH_RST;
      rect_depth_r <= rsp_pkg::RECT_DEPTH_RST;
      axis_x_r     <= rsp_pkg::AXIS_X_ROW_RST;
      axis_z_r     <= rsp_pkg::AXIS_Z_ROW_RST;
      trans_r      <= rsp_pkg::TRANSLATION_ROW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rsp_pkg::REG_RECT_WIDTH:      rect_width_r <= cfg_wdata[rsp_pkg::ExtW-1:0];
        rsp_pkg::REG_RECT_DEPTH:      rect_depth_r <= cfg_wdata[rsp_pkg::ExtW-1:0];
        rsp_pkg::REG_AXIS_X_ROW:      axis_x_r     <= cfg_wdata;
        rsp_pkg::REG_AXIS_Z_ROW:      axis_z_r     <= cfg_wdata;
        rsp_pkg::REG_TRANSLATION_ROW: trans_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign en3      = !v3_r || !out_stall;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  assign dir[0] = in_data.dir_x;
  assign dir[1] = in_data.dir_y;
  assign dir[2] = in_data.dir_z;

  assign ctrl.en1    = en1;
  assign ctrl.en2    = en2;
  assign ctrl.en3    = en3;
  assign ctrl.sx_pos = sx_pos;
  assign ctrl.sz_pos = sz_pos;

  for (genvar k = 0; k < 3; k++) begin : g_lane
    rsp_lane u_lane (
      .clk      (clk),
      .ctrl     (ctrl),
      .dir      (dir[k]),
      .ax       (axis_x_r[16*k +: 16]),
      .az       (axis_z_r[16*k +: 16]),
      .w        (rect_width_r),
      .d        (rect_depth_r),
      .t        (trans_r[16*k +: 16]),
      .prod_x_r (prod_x[k]),
      .prod_z_r (prod_z[k]),
      .coord_r  (coord[k])
    );
  end

  // Direction dotted with each local axis; extents only scale, never flip, these sums
  assign sa_nxt = rsp_pkg::SumW'(prod_x[0]) + rsp_pkg::SumW'(prod_x[1])
                + rsp_pkg::SumW'(prod_x[2]);
  assign sb_nxt = rsp_pkg::SumW'(prod_z[0]) + rsp_pkg::SumW'(prod_z[1])
                + rsp_pkg::SumW'(prod_z[2]);

  always_ff @(posedge clk) begin
    if (en2) begin
      sa_r <= sa_nxt;
      sb_r <= sb_nxt;
    end
  end

  // Projection separates into x and z parts: take the sign of each, lower index on a tie
  assign px_pos  = (rect_width_r != '0) && !sa_r[rsp_pkg::SumW-1] && (sa_r != '0);
  assign px_zero = (rect_width_r == '0) || (sa_r == '0);
  assign pz_pos  = (rect_depth_r != '0) && !sb_r[rsp_pkg::SumW-1] && (sb_r != '0);
  assign sx_pos  = px_pos || (px_zero && pz_pos);
  assign sz_pos  = pz_pos;

  always_comb begin
    case ({sx_pos, sz_pos})
      2'b00:   corner_nxt = rsp_pkg::CORNER_NEG_NEG;
      2'b10:   corner_nxt = rsp_pkg::CORNER_POS_NEG;
      2'b11:   corner_nxt = rsp_pkg::CORNER_POS_POS;
      2'b01:   corner_nxt = rsp_pkg::CORNER_NEG_POS;
      default: corner_nxt = rsp_pkg::CORNER_NEG_NEG;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      corner_r <= corner_nxt;
    end
  end

  assign out_valid             = v3_r;
  assign out_data.point_x      = coord[0];
  assign out_data.point_y      = coord[1];
  assign out_data.point_z      = coord[2];
  assign out_data.corner_index = corner_r;

  `RSP_ASSERT_NEXT(a_in_fills_s1, in_valid && !in_stall, v1_r)
  `RSP_ASSERT_NOW(a_stall_only_when_full, in_stall, v1_r && v2_r && v3_r && out_stall)
  `RSP_ASSERT_NEXT(a_zero_dir_corner0, v2_r && en3 && sa_r == '0 && sb_r == '0, out_data.corner_index == rsp_pkg::CORNER_NEG_NEG)
  `RSP_ASSERT_NEXT(a_drain_empties, out_valid && !out_stall && !v2_r, !out_valid)

endmodule

// File: tb/tb.sv
// Self-checking testbench for the rectangle support point unit.
module tb;

  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 2000;
  localparam int NUM_PHASES    = 6;
  localparam int DIRS_PER_PHASE = 296;
  localparam logic [rsp_pkg::CfgIdxW-1:0] UNUSED_IDX_FIRST = 3'd5;
  localparam logic [rsp_pkg::CfgIdxW-1:0] UNUSED_IDX_LAST  = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rsp_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [rsp_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [rsp_pkg::RowW-1:0] cfg_wdata = '0;

  // local copy of the register file
  logic [rsp_pkg::ExtW-1:0] cur_width = rsp_pkg::RECT_WIDTH_RST;
  logic [rsp_pkg::ExtW-1:0] cur_depth = rsp_pkg::RECT_DEPTH_RST;
  logic [rsp_pkg::RowW-1:0] cur_axis_x = rsp_pkg::AXIS_X_ROW_RST;
  logic [rsp_pkg::RowW-1:0] cur_axis_z = rsp_pkg::AXIS_Z_ROW_RST;
  logic [rsp_pkg::RowW-1:0] cur_trans = rsp_pkg::TRANSLATION_ROW_RST;

  rsp_pkg::in_item_t pending_dirs[$];
  rsp_pkg::out_item_t expected_points[$];
  int mismatch_count = 0;
  int send_idle_pct = 10;
  int recv_idle_pct = 45;
  int pressure_req = 0;
  int pressure_ack = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  logic in_xfer = 1'b0;

  rectangle_support_point_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Q.23 corner coordinate to Q12.8, round half up, saturate
  function automatic logic signed [rsp_pkg::PointW-1:0] to_q12_8(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 524287) r = 524287;
    if (r < -524288) r = -524288;
    return r[rsp_pkg::PointW-1:0];
  endfunction

  function automatic rsp_pkg::out_item_t support_point(input rsp_pkg::in_item_t d);
    longint dir_v[3];
    longint pt[4][3];
    longint proj, best, half_w, half_d;
    int sel, c, k;
    rsp_pkg::out_item_t res;
    dir_v[0] = longint'(d.dir_x);
    dir_v[1] = longint'(d.dir_y);
    dir_v[2] = longint'(d.dir_z);
    best = 0;
    sel = 0;
    for (c = 0; c < 4; c++) begin
      half_w = (c == rsp_pkg::CORNER_POS_NEG || c == rsp_pkg::CORNER_POS_POS) ?
               longint'(cur_width) : -longint'(cur_width);
      half_d = (c == rsp_pkg::CORNER_POS_POS || c == rsp_pkg::CORNER_NEG_POS) ?
               longint'(cur_depth) : -longint'(cur_depth);
      proj = 0;
      for (k = 0; k < 3; k++) begin
        pt[c][k] = longint'($signed(cur_trans[16*k +: 16])) * 32768
                 + half_w * longint'($signed(cur_axis_x[16*k +: 16]))
                 + half_d * longint'($signed(cur_axis_z[16*k +: 16]));
        proj += dir_v[k] * pt[c][k];
      end
      // strict compare keeps the lower index on a tie
      if (c == 0 || proj > best) begin
        best = proj;
        sel = c;
      end
    end
    res.point_x = to_q12_8(pt[sel][0]);
    res.point_y = to_q12_8(pt[sel][1]);
    res.point_z = to_q12_8(pt[sel][2]);
    res.corner_index = sel[1:0];
    return res;
  endfunction

  task automatic queue_dir(input int x, input int y, input int z);
    rsp_pkg::in_item_t d;
    d.dir_x = x[rsp_pkg::DirW-1:0];
    d.dir_y = y[rsp_pkg::DirW-1:0];
    d.dir_z = z[rsp_pkg::DirW-1:0];
    pending_dirs.push_back(d);
  endtask

  task automatic write_reg(input logic [rsp_pkg::CfgIdxW-1:0] idx,
                           input logic [rsp_pkg::RowW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_dirs.size() != 0 || in_valid || expected_points.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic [rsp_pkg::RowW-1:0] rand_row();
    return rsp_pkg::RowW'({$urandom(), $urandom()});
  endfunction

  // Sender: hold a stalled transfer, otherwise offer the next direction
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_xfer) begin
      if (pending_dirs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_dirs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (pressure_ack != pressure_req) begin
      pressure_ack <= pressure_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Predict on input transfers, check on output transfers
  always @(posedge clk) begin
    rsp_pkg::out_item_t e;
    if (!rst_n) begin
      in_xfer <= 1'b0;
    end else begin
      in_xfer <= in_valid && !in_stall;
      if (cfg_we) begin
        case (cfg_index)
          rsp_pkg::REG_RECT_WIDTH:      cur_width = cfg_wdata[rsp_pkg::ExtW-1:0];
          rsp_pkg::REG_RECT_DEPTH:      cur_depth = cfg_wdata[rsp_pkg::ExtW-1:0];
          rsp_pkg::REG_AXIS_X_ROW:      cur_axis_x = cfg_wdata;
          rsp_pkg::REG_AXIS_Z_ROW:      cur_axis_z = cfg_wdata;
          rsp_pkg::REG_TRANSLATION_ROW: cur_trans = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_points.push_back(support_point(in_data));
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: x=%0d y=%0d z=%0d corner=%0d",
                     out_data.point_x, out_data.point_y, out_data.point_z,
                     out_data.corner_index);
        end else begin
          e = expected_points.pop_front();
          if (out_data.point_x !== e.point_x || out_data.point_y !== e.point_y ||
              out_data.point_z !== e.point_z ||
              out_data.corner_index !== e.corner_index) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: exp %0d %0d %0d c%0d, got %0d %0d %0d c%0d",
                       e.point_x, e.point_y, e.point_z, e.corner_index,
                       out_data.point_x, out_data.point_y, out_data.point_z,
                       out_data.corner_index);
          end
        end
      end
    end
  end

  // Watchdog: end the run if nothing transfers for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int ph, n, pick;
    logic [rsp_pkg::RowW-1:0] ax, az;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed directions under the reset geometry, ties and zero included
    queue_dir(0, 0, 0);
    queue_dir(1, 0, 0);
    queue_dir(-1, 0, 0);
    queue_dir(0, 0, 1);
    queue_dir(0, 0, -1);
    queue_dir(0, 1, 0);
    queue_dir(0, -32768, 0);
    queue_dir(1, 0, 1);
    queue_dir(-1, 0, 1);
    queue_dir(1, 0, -1);
    queue_dir(-1, 0, -1);
    queue_dir(32767, 32767, 32767);
    queue_dir(-32768, -32768, -32768);
    queue_dir(32767, -32768, 0);
    queue_dir(-32768, 0, 32767);
    queue_dir(-1, -1, -1);
    wait_drained();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          // largest extents, most negative x axis, extreme z axis and translation
          write_reg(rsp_pkg::REG_RECT_WIDTH, 48'hFFFF_FFFF_FFFF);
          write_reg(rsp_pkg::REG_RECT_DEPTH, 48'h0000_0000_FFFF);
          write_reg(rsp_pkg::REG_AXIS_X_ROW, 48'h8000_8000_8000);
          write_reg(rsp_pkg::REG_AXIS_Z_ROW, 48'h7FFF_8000_7FFF);
          write_reg(rsp_pkg::REG_TRANSLATION_ROW, 48'h7FFF_8000_7FFF);
        end
        1: begin
          // degenerate rectangle: every corner coincides
          write_reg(rsp_pkg::REG_RECT_WIDTH, 48'h0);
          write_reg(rsp_pkg::REG_RECT_DEPTH, 48'hABCD_0000_0000);
          write_reg(rsp_pkg::REG_AXIS_X_ROW, 48'h0);
          write_reg(rsp_pkg::REG_AXIS_Z_ROW, 48'hFFFF_FFFF_FFFF);
          write_reg(rsp_pkg::REG_TRANSLATION_ROW, 48'h8000_7FFF_8000);
        end
        default: begin
          ax = rand_row();
          az = rand_row();
          // drop the y lane now and then so ties on x-z directions show up
          if ($urandom_range(2) == 0) begin
            ax[31:16] = '0;
            az[31:16] = '0;
          end
          write_reg(rsp_pkg::REG_RECT_WIDTH, ($urandom_range(1) != 0) ? rand_row() :
                    rsp_pkg::RowW'($urandom_range(1023)));
          write_reg(rsp_pkg::REG_RECT_DEPTH, rand_row());
          write_reg(rsp_pkg::REG_AXIS_X_ROW, ax);
          write_reg(rsp_pkg::REG_AXIS_Z_ROW, az);
          write_reg(rsp_pkg::REG_TRANSLATION_ROW, rand_row());
        end
      endcase
      write_reg(rsp_pkg::CfgIdxW'($urandom_range(UNUSED_IDX_LAST, UNUSED_IDX_FIRST)),
                rand_row());

      if (ph < 2) begin
        send_idle_pct = 10;
        recv_idle_pct = 45;
      end else if (ph < 4) begin
        send_idle_pct = 45;
        recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      @(posedge clk);
      queue_dir(0, 0, 0);
      queue_dir(32767, 32767, 32767);
      queue_dir(-32768, -32768, -32768);
      queue_dir(-32768, 32767, -32768);
      for (n = 0; n < DIRS_PER_PHASE; n++) begin
        pick = $urandom_range(9);
        if (pick < 6)
          queue_dir($urandom(), $urandom(), $urandom());
        else if (pick < 8)
          queue_dir(int'($urandom_range(4)) - 2, int'($urandom_range(4)) - 2,
                    int'($urandom_range(4)) - 2);
        else if (pick == 8)
          queue_dir(($urandom_range(1) != 0) ? $urandom() : 0, 0,
                    ($urandom_range(1) != 0) ? $urandom() : 0);
        else
          queue_dir(($urandom_range(1) != 0) ? 32767 : -32768,
                    ($urandom_range(1) != 0) ? 32767 : -32768,
                    ($urandom_range(1) != 0) ? 32767 : -32768);
      end
      if (ph == 1 || ph == 4)
        pressure_req = pressure_req + 1;
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_points.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
